### rtl/gcpf_pkg.sv
// Shared types, constants and the packet length decoder for the command framer.
`timescale 1ns / 1ps
package gcpf_pkg;

  // Sizes
  localparam int unsigned HIST_ENTRIES = 256;
  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned S_DATA_W     = 40;
  localparam int unsigned M_DATA_W     = 112;

  // Transaction kinds on the input side
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } gcpf_op_e;

  // Command class masks and codes
  localparam logic [7:0] CLASS_MASK = 8'hE0;
  localparam logic [7:0] CLASS_POLY = 8'h20;
  localparam logic [7:0] CLASS_RECT = 8'h60;
  localparam logic [7:0] CLASS_LINE = 8'h40;
  localparam logic [7:0] CLASS_XFR1 = 8'hA0;
  localparam logic [7:0] CLASS_XFR2 = 8'hC0;
  localparam logic [7:0] BIT_SHADE  = 8'h10;
  localparam logic [7:0] BIT_QUAD   = 8'h08;
  localparam logic [7:0] BIT_TEX    = 8'h04;
  localparam int unsigned CMD_SHIFT = 24;

  // One item on its way from the framer to the histogram stage
  typedef struct packed {
    logic        header;
    logic [7:0]  cmd;
    logic [3:0]  left;
    logic [31:0] word_total;
    logic [31:0] packet_total;
    logic [7:0]  hist_addr;
    logic        hist_inc;
  } gcpf_item_t;

  // Parameter words following a header with the given command byte
  function automatic logic [3:0] param_words(input logic [7:0] code);
    logic [4:0] verts;
    logic [4:0] mult;
    logic [4:0] cnt;
    verts = ((code & BIT_QUAD) != 8'h00) ? 5'd4 : 5'd3;
    mult  = 5'd1 + (((code & BIT_TEX) != 8'h00) ? 5'd1 : 5'd0)
                 + (((code & BIT_SHADE) != 8'h00) ? 5'd1 : 5'd0);
    cnt   = 5'd0;
    case (code & CLASS_MASK)
      CLASS_POLY: begin
        // shaded polygons carry no trailing word, flat ones one more
        if ((code & BIT_SHADE) != 8'h00) begin
          cnt = 5'(verts * mult) - 5'd1;
        end else begin
          cnt = 5'(verts * mult);
        end
      end
      CLASS_RECT: cnt = ((code & BIT_TEX) != 8'h00) ? 5'd3 : 5'd2;
      CLASS_LINE: cnt = 5'd3;
      CLASS_XFR1: cnt = 5'd2;
      CLASS_XFR2: cnt = 5'd2;
      default:    cnt = 5'd0;
    endcase
    return cnt[3:0];
  endfunction

endpackage

### rtl/gpu_command_packet_framer.sv
// Top level of the graphics command packet framer with its output register.
//
//  Channel  Direction  tdata (low bit up)                       tuser
//  s_axis   in         data_word[31:0] hist_index[39:32]        opcode
//  m_axis   out        command_code[7:0] words_remaining[11:8]  header_flag
//                      word_total[43:12] packet_total[75:44]
//                      hist_count[107:76], zero up to bit 111
//
// One transaction is accepted per cycle while the pipeline is not stalled; a
// result passes from its input transaction through the framing registers,
// then the histogram RAM read and forwarded update, then the output register.
// The rate is set by the read-modify-write on the histogram RAM. Reset clears
// the framing state and the 256 entry valid bits at once; no clearing pass is
// needed. A stall on m_axis holds the pipeline and drops s_axis_tready once
// stage 1 is also full.
`timescale 1ns / 1ps
module gpu_command_packet_framer #(
  parameter int unsigned HistEntries = gcpf_pkg::HIST_ENTRIES,
  parameter int unsigned CountWidth  = gcpf_pkg::COUNT_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_word[31:0], hist_index[39:32]
  input  logic [gcpf_pkg::S_DATA_W-1:0] s_axis_tdata,
  // opcode[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // command_code[7:0], words_remaining[11:8], word_total[43:12],
  // packet_total[75:44], hist_count[107:76], zero fill [111:108]
  output logic [gcpf_pkg::M_DATA_W-1:0] m_axis_tdata,
  // header_flag[0]
  output logic                          m_axis_tuser
);

  import gcpf_pkg::*;

  logic        acc;
  logic        adv;
  logic        s1_valid;
  gcpf_item_t  fr_item;
  gcpf_item_t  s1_item;
  logic [31:0] s1_hist;
  logic        out_valid_q, out_valid_d;
  gcpf_item_t  out_item_q;
  logic [31:0] out_hist_q;

  // Handshake: stage 1 moves on whenever the output register is empty or being read
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid || adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  gcpf_framer #(
    .CountWidth (CountWidth)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .op_i         (s_axis_tuser),
    .data_word_i  (s_axis_tdata[31:0]),
    .hist_index_i (s_axis_tdata[39:32]),
    .item_o       (fr_item)
  );

  gcpf_hist #(
    .HistEntries (HistEntries),
    .CountWidth  (CountWidth)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (fr_item),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item),
    .hist_o     (s1_hist)
  );

  // Output register
  assign out_valid_d = adv ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid) begin
      out_item_q <= s1_item;
      out_hist_q <= s1_hist;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_item_q.header;
  assign m_axis_tdata  = {4'd0, out_hist_q, out_item_q.packet_total,
                          out_item_q.word_total, out_item_q.left, out_item_q.cmd};

  // Input side only stalls behind a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // A header result carries a nonzero packet total and histogram count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[75:44] != 32'd0) && (m_axis_tdata[107:76] != 32'd0)))
    else $error("header result with zero count");

  // A result only appears after stage 1 held an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_valid))
    else $error("output valid without a stage 1 item");

endmodule

### rtl/gcpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gcpf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, old data on a same-cycle collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/gcpf_framer.sv
// Packet framing state: header detection, length countdown and saturating totals.
`timescale 1ns / 1ps
module gcpf_framer #(
  parameter int unsigned CountWidth = gcpf_pkg::COUNT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                op_i,
  input  logic [31:0]         data_word_i,
  input  logic [7:0]          hist_index_i,
  output gcpf_pkg::gcpf_item_t item_o
);

  import gcpf_pkg::*;

  logic [3:0]            left_q, left_d;
  logic [7:0]            cmd_q, cmd_d;
  logic [CountWidth-1:0] words_q, words_d;
  logic [CountWidth-1:0] packets_q, packets_d;
  logic                  push;
  logic                  header;
  logic [7:0]            new_cmd;
  logic [63:0]           words_ext;
  logic [63:0]           packets_ext;

  assign push    = (op_i == OP_PUSH);
  assign header  = push && (left_q == 4'd0);
  assign new_cmd = data_word_i[CMD_SHIFT +: 8];

  // Next state of the framing registers
  always_comb begin
    left_d    = left_q;
    cmd_d     = cmd_q;
    words_d   = words_q;
    packets_d = packets_q;
    if (push) begin
      words_d = (words_q == '1) ? words_q : words_q + 1'b1;
      if (header) begin
        cmd_d     = new_cmd;
        left_d    = param_words(new_cmd);
        packets_d = (packets_q == '1) ? packets_q : packets_q + 1'b1;
      end else begin
        left_d = left_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      cmd_q     <= '0;
      words_q   <= '0;
      packets_q <= '0;
    end else if (acc_i) begin
      left_q    <= left_d;
      cmd_q     <= cmd_d;
      words_q   <= words_d;
      packets_q <= packets_d;
    end
  end

  // Item view after this transaction; totals show their low 32 bits
  assign words_ext   = 64'(words_d);
  assign packets_ext = 64'(packets_d);

  always_comb begin
    item_o.header       = header;
    item_o.cmd          = cmd_d;
    item_o.left         = left_d;
    item_o.word_total   = words_ext[31:0];
    item_o.packet_total = packets_ext[31:0];
    item_o.hist_addr    = push ? cmd_d : hist_index_i;
    item_o.hist_inc     = header;
  end

endmodule

### rtl/gcpf_hist.sv
// Command histogram: RAM read, forwarded read-modify-write and entry valid bits.
`timescale 1ns / 1ps
module gcpf_hist #(
  parameter int unsigned HistEntries = gcpf_pkg::HIST_ENTRIES,
  parameter int unsigned CountWidth  = gcpf_pkg::COUNT_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  gcpf_pkg::gcpf_item_t item_i,
  input  logic                 adv_i,
  output logic                 s1_valid_o,
  output gcpf_pkg::gcpf_item_t s1_item_o,
  output logic [31:0]          hist_o
);

  import gcpf_pkg::*;

  localparam int unsigned AddrW = $clog2(HistEntries);

  logic                   s1_valid_q, s1_valid_d;
  gcpf_item_t             s1_item_q;
  logic [HistEntries-1:0] valid_q;
  logic                   fwd_valid_q;
  logic [AddrW-1:0]       fwd_addr_q;
  logic [CountWidth-1:0]  fwd_data_q;
  logic [CountWidth-1:0]  ram_q;
  logic [AddrW-1:0]       s1_addr;
  logic [CountWidth-1:0]  old_cnt;
  logic [CountWidth-1:0]  new_cnt;
  logic                   wr_en;
  logic [63:0]            new_ext;

  assign s1_addr = s1_item_q.hist_addr[AddrW-1:0];
  assign wr_en   = s1_valid_q && adv_i && s1_item_q.hist_inc;

  gcpf_ram #(
    .Width (CountWidth),
    .Depth (HistEntries)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr),
    .wr_data_i (new_cnt),
    .rd_en_i   (acc_i),
    .rd_addr_i (item_i.hist_addr[AddrW-1:0]),
    .rd_data_o (ram_q)
  );

  // Stage 1 holds the item whose RAM read is in flight; an empty stage
  // takes a transaction even while the output is stalled
  assign s1_valid_d = acc_i || (s1_valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_item_q <= item_i;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_addr] <= 1'b1;
    end
  end

  // Last write, covering a read issued in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= new_cnt;
    end
  end

  // Current count and saturating update
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      old_cnt = fwd_data_q;
    end else if (valid_q[s1_addr]) begin
      old_cnt = ram_q;
    end else begin
      old_cnt = '0;
    end
    if (s1_item_q.hist_inc && (old_cnt != '1)) begin
      new_cnt = old_cnt + 1'b1;
    end else begin
      new_cnt = old_cnt;
    end
  end

  assign new_ext    = 64'(new_cnt);
  assign hist_o     = new_ext[31:0];
  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule
